/* rtl/i2c_bus_clear_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// I2C bus clear sequencer assertion macros
// Clocked assertion wrappers shared by the RTL; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH
`define I2C_BUS_CLEAR_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// assertion sampled on clk, off while rst is high
`define BCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on clk, also checked during reset
`define BCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BCS_ASSERT(lbl, clk, rst, prop, msg)
`define BCS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/i2c_bcs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C bus clear sequencer package
// Beat types, configuration struct, phase encoding and register indexes.
// ----------------------------------------------------------------------------
package i2c_bcs_pkg;

   // width of the phase tick counter and of the phase length compare
   localparam int DELAY_WIDTH = 16;

   // configuration port
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_HALF_PERIOD  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PULSES   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_PINS_PRESENT = CSR_IDX_W'(3);

   // reset values of the configuration registers
   localparam logic [15:0] RST_HALF_PERIOD = 16'd320;
   localparam logic [3:0]  RST_MAX_PULSES  = 4'd9;
   localparam logic [15:0] RST_SETTLE      = 16'd100;

   // status codes reported with done
   localparam logic [1:0] RC_RECOVERED   = 2'd0;
   localparam logic [1:0] RC_STUCK       = 2'd1;
   localparam logic [1:0] RC_UNSUPPORTED = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_WAIT0    = 4'd1,
      PH_LOW      = 4'd2,
      PH_HIGH     = 4'd3,
      PH_SDA_LOW  = 4'd4,
      PH_SCL_REL  = 4'd5,
      PH_SDA_REL  = 4'd6,
      PH_SETTLE   = 4'd7
   } phase_type;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [3:0]  max_pulses;
      logic [15:0] settle_ticks;
      logic        pins_present;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic scl_level;
      logic sda_level;
   } req_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       pins_taken_over;
      logic       busy_res;
      logic       done_res;
      logic [1:0] result_code;
   } rsp_type;

endpackage

/* rtl/i2c_bcs_regs.sv */
// ----------------------------------------------------------------------------
// I2C bus clear sequencer configuration registers
// Write-only register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module i2c_bcs_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [i2c_bcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2c_bcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output i2c_bcs_pkg::cfg_type             cfg
);
   import i2c_bcs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_HALF_PERIOD:  cfg_in.half_period_ticks = csr_wdata[15:0];
            REG_MAX_PULSES:   cfg_in.max_pulses        = csr_wdata[3:0];
            REG_SETTLE:       cfg_in.settle_ticks      = csr_wdata[15:0];
            REG_PINS_PRESENT: cfg_in.pins_present      = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= RST_HALF_PERIOD;
         cfg_ff.max_pulses        <= RST_MAX_PULSES;
         cfg_ff.settle_ticks      <= RST_SETTLE;
         cfg_ff.pins_present      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/i2c_bcs_core.sv */
// ----------------------------------------------------------------------------
// I2C bus clear sequencer core
// Recovery state machine; advances one tick for each beat handed to it.
// ----------------------------------------------------------------------------
`include "i2c_bus_clear_sequencer_assert.svh"

module i2c_bcs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  i2c_bcs_pkg::req_type item,
   input  i2c_bcs_pkg::cfg_type cfg,
   output i2c_bcs_pkg::rsp_type rsp_out
);
   import i2c_bcs_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [3:0]             pulse_ff, pulse_in;
   logic                   recovered_ff, recovered_in;

   logic [DELAY_WIDTH-1:0] tick_inc;
   logic [DELAY_WIDTH-1:0] limit;
   logic [3:0]             pulse_inc;
   logic                   tick_end;
   logic                   both_high;
   logic                   running;

   // phase timer
   assign running   = phase_ff inside {PH_WAIT0, PH_LOW, PH_HIGH, PH_SDA_LOW,
                                       PH_SCL_REL, PH_SDA_REL, PH_SETTLE};
   assign tick_inc  = tick_count_ff + DELAY_WIDTH'(1);
   assign limit     = (phase_ff == PH_SETTLE) ? DELAY_WIDTH'(cfg.settle_ticks)
                                              : DELAY_WIDTH'(cfg.half_period_ticks);
   assign tick_end  = (tick_inc >= limit);
   assign both_high = item.scl_level & item.sda_level;
   assign pulse_inc = pulse_ff + 4'd1;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_end ? '0 : tick_inc;
      pulse_in      = pulse_ff;
      recovered_in  = recovered_ff;
      case (phase_ff)
         PH_WAIT0: begin
            if (tick_end) begin
               phase_in = (pulse_ff < cfg.max_pulses && !both_high) ? PH_LOW : PH_SDA_LOW;
            end
         end
         PH_LOW: begin
            if (tick_end) phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            if (tick_end) begin
               pulse_in = pulse_inc;
               phase_in = (pulse_inc < cfg.max_pulses && !both_high) ? PH_LOW : PH_SDA_LOW;
            end
         end
         PH_SDA_LOW: begin
            if (tick_end) phase_in = PH_SCL_REL;
         end
         PH_SCL_REL: begin
            if (tick_end) phase_in = PH_SDA_REL;
         end
         PH_SDA_REL: begin
            if (tick_end) begin
               recovered_in = both_high;
               phase_in     = PH_SETTLE;
            end
         end
         PH_SETTLE: begin
            if (tick_end) phase_in = PH_IDLE;
         end
         default: begin
            // idle, and any stray code falls back to idle
            phase_in      = PH_IDLE;
            tick_count_in = tick_count_ff;
            if (item.start_req && cfg.pins_present) begin
               phase_in      = PH_WAIT0;
               tick_count_in = '0;
               pulse_in      = 4'd0;
               recovered_in  = 1'b0;
            end
         end
      endcase
   end

   // outputs: line drives follow the phase after this tick
   always_comb begin
      rsp_out                 = '0;
      rsp_out.busy_res        = (phase_in != PH_IDLE);
      rsp_out.pins_taken_over = (phase_in != PH_IDLE) && (phase_in != PH_SETTLE);
      rsp_out.scl_drive_low   = (phase_in == PH_LOW);
      rsp_out.sda_drive_low   = (phase_in == PH_SDA_LOW) || (phase_in == PH_SCL_REL);
      if (!running && item.start_req && !cfg.pins_present) begin
         rsp_out.done_res    = 1'b1;
         rsp_out.result_code = RC_UNSUPPORTED;
      end else if (phase_ff == PH_SETTLE && tick_end) begin
         rsp_out.done_res    = 1'b1;
         rsp_out.result_code = recovered_ff ? RC_RECOVERED : RC_STUCK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         pulse_ff      <= 4'd0;
         recovered_ff  <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         pulse_ff      <= pulse_in;
         recovered_ff  <= recovered_in;
      end
   end

   // a finished sequence lands in idle
   `BCS_ASSERT(a_done_to_idle, clock, reset, step && rsp_out.done_res && rsp_out.result_code != RC_UNSUPPORTED |=> phase_ff == PH_IDLE, "sequence end did not return to idle")
   // a start with pins present opens the initial wait
   `BCS_ASSERT(a_start_wait, clock, reset, step && !running && item.start_req && cfg.pins_present |=> phase_ff == PH_WAIT0, "start did not enter initial wait")
   // state only moves on a beat
   `BCS_ASSERT(a_hold_no_step, clock, reset, !step |=> $stable(phase_ff) && $stable(tick_count_ff) && $stable(pulse_ff), "state moved without a beat")

endmodule

/* rtl/i2c_bus_clear_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C bus clear sequencer
// Each request beat is one clock tick of the recovery sequence with the sampled
// SCL and SDA levels; each one yields exactly one response beat holding the line
// drives and status after that tick. A beat is held in the input register and
// moves to the response register when that slot is free or draining, so its
// response is offered from the response register; one beat per cycle is
// sustained while the response side does not stall, with the state update of
// the core between the two registers. Configuration registers reset to half
// period 320, 9 pulses, settle 100, pins present.
// ----------------------------------------------------------------------------
`include "i2c_bus_clear_sequencer_assert.svh"

module i2c_bus_clear_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  i2c_bcs_pkg::req_type               req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output i2c_bcs_pkg::rsp_type               rsp_data,
   // configuration
   input  logic                               csr_we,
   input  logic [i2c_bcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2c_bcs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import i2c_bcs_pkg::*;

   cfg_type cfg;
   req_type item_ff;
   logic    in_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_out;
   logic    out_valid_ff;
   logic    advance;
   logic    req_take;

   i2c_bcs_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2c_bcs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .rsp_out (rsp_out)
   );

   // beat moves to the response register when that slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_data;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_out;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted beat is held in the input register next cycle
   `BCS_ASSERT(a_take_loads, clock, reset, req_take |=> in_valid_ff, "accepted beat lost")
   // a beat passed to the core shows up as a response
   `BCS_ASSERT(a_adv_out, clock, reset, advance |=> out_valid_ff, "advanced beat not offered")
   // an empty response slot never stalls the request side
   `BCS_ASSERT_ALWAYS(a_no_false_stall, clock, !out_valid_ff |-> !req_stall, "stall with free response slot")

endmodule

/* tb/bus_clear_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus clear sequencer response monitor
// Watches the request, response and register ports. Keeps its own copy of the
// recovery state machine and register file, computes the line drives and
// status each request beat should produce, and compares every response beat
// against the oldest pending prediction. Failures are counted for the top.
// ----------------------------------------------------------------------------
module bus_clear_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  i2c_bcs_pkg::req_type               req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  i2c_bcs_pkg::rsp_type               rsp_data,
   input  logic                               csr_we,
   input  logic [i2c_bcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2c_bcs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                 fail_count,
   output int                                 outstanding
);
   import i2c_bcs_pkg::*;

   localparam int DW = DELAY_WIDTH;

   // shadow register file and recovery state
   cfg_type          cfg;
   phase_type        seq_phase;
   logic [DW-1:0]    tick_cnt;
   logic [3:0]       pulse_cnt;
   logic             recov;

   // predicted line drives and status, oldest first
   rsp_type          line_states_q[$];

   // another SCL pulse unless the pulse budget is spent or both lines are free
   function automatic phase_type pulse_or_close(req_type r);
      if (pulse_cnt < cfg.max_pulses && !(r.scl_level && r.sda_level))
         return PH_LOW;
      return PH_SDA_LOW;
   endfunction

   // one tick of the recovery sequencer
   task automatic advance_recovery(input req_type r, output rsp_type o);
      logic [DW-1:0] limit;
      logic          done;
      logic [1:0]    code;
      done = 1'b0;
      code = RC_RECOVERED;
      if (seq_phase == PH_IDLE || seq_phase > PH_SETTLE) begin
         seq_phase = PH_IDLE;
         if (r.start_req) begin
            if (!cfg.pins_present) begin
               done = 1'b1;
               code = RC_UNSUPPORTED;
            end else begin
               seq_phase = PH_WAIT0;
               tick_cnt  = '0;
               pulse_cnt = '0;
               recov     = 1'b0;
            end
         end
      end else begin
         limit = (seq_phase == PH_SETTLE) ? DW'(cfg.settle_ticks)
                                          : DW'(cfg.half_period_ticks);
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt >= limit) begin
            tick_cnt = '0;
            case (seq_phase)
               PH_WAIT0:   seq_phase = pulse_or_close(r);
               PH_LOW:     seq_phase = PH_HIGH;
               PH_HIGH: begin
                  pulse_cnt = pulse_cnt + 1'b1;
                  seq_phase = pulse_or_close(r);
               end
               PH_SDA_LOW: seq_phase = PH_SCL_REL;
               PH_SCL_REL: seq_phase = PH_SDA_REL;
               PH_SDA_REL: begin
                  recov     = r.scl_level && r.sda_level;
                  seq_phase = PH_SETTLE;
               end
               default: begin
                  seq_phase = PH_IDLE;
                  done      = 1'b1;
                  code      = recov ? RC_RECOVERED : RC_STUCK;
               end
            endcase
         end
      end
      // outputs reflect the state after this tick
      o = '0;
      if (seq_phase != PH_IDLE) begin
         o.busy_res        = 1'b1;
         o.pins_taken_over = (seq_phase != PH_SETTLE);
         o.scl_drive_low   = (seq_phase == PH_LOW);
         o.sda_drive_low   = (seq_phase == PH_SDA_LOW) || (seq_phase == PH_SCL_REL);
      end
      o.done_res    = done;
      o.result_code = code;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg.half_period_ticks = RST_HALF_PERIOD;
         cfg.max_pulses        = RST_MAX_PULSES;
         cfg.settle_ticks      = RST_SETTLE;
         cfg.pins_present      = 1'b1;
         seq_phase  = PH_IDLE;
         tick_cnt   = '0;
         pulse_cnt  = '0;
         recov      = 1'b0;
         fail_count = 0;
         line_states_q.delete();
      end else begin
         // register writes take effect immediately; unknown indexes are dropped
         if (csr_we) begin
            case (csr_index)
               REG_HALF_PERIOD:  cfg.half_period_ticks = csr_wdata[15:0];
               REG_MAX_PULSES:   cfg.max_pulses        = csr_wdata[3:0];
               REG_SETTLE:       cfg.settle_ticks      = csr_wdata[15:0];
               REG_PINS_PRESENT: cfg.pins_present      = csr_wdata[0];
               default: ;
            endcase
         end
         // response beat against oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (line_states_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, got %h",
                        $time, rsp_data);
               fail_count++;
            end else begin
               want = line_states_q.pop_front();
               check_field("scl_drive_low", want.scl_drive_low, rsp_data.scl_drive_low);
               check_field("sda_drive_low", want.sda_drive_low, rsp_data.sda_drive_low);
               check_field("pins_taken_over", want.pins_taken_over,
                           rsp_data.pins_taken_over);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("result_code", want.result_code, rsp_data.result_code);
            end
         end
         // request beat: one tick of the sequencer
         if (req_valid && !req_stall) begin
            advance_recovery(req_data, want);
            line_states_q.push_back(want);
         end
      end
      outstanding = line_states_q.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bus clear sequencer testbench
// Feeds tick beats with start requests and sampled line levels under a series
// of register settings: a directed pass over stuck, recovered, unsupported and
// long-phase cases, then random phases with random handshake gaps, one burst
// against a long response hold-off, and a drain before every register update.
// ----------------------------------------------------------------------------
module tb;
   import i2c_bcs_pkg::*;

   localparam int TARGET_BEATS = 650;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;

   // burst handshake between stimulus and response side
   bit                    hold_on;
   bit                    hold_done;

   i2c_bus_clear_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bus_clear_monitor mon (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   // phase length: mostly short, sometimes mid, rarely the full range
   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 3));
      if (r < 93) return 16'($urandom_range(4, 20));
      return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'($urandom);
   endfunction

   function automatic req_type draw_item(int p_high, int p_start);
      req_type d;
      d.start_req = ($urandom_range(0, 99) < p_start);
      if ($urandom_range(0, 99) < p_high) begin
         d.scl_level = 1'b1;
         d.sda_level = 1'b1;
      end else begin
         d.scl_level = 1'($urandom_range(0, 1));
         d.sda_level = 1'($urandom_range(0, 1));
      end
      return d;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(req_type d, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic program_cfg(cfg_type c, bit stray);
      if (stray)
         write_reg(REG_PINS_PRESENT + CSR_IDX_W'($urandom_range(1, 252)),
                   CSR_DATA_W'($urandom));
      write_reg(REG_HALF_PERIOD, c.half_period_ticks);
      write_reg(REG_MAX_PULSES, CSR_DATA_W'(c.max_pulses));
      write_reg(REG_SETTLE, c.settle_ticks);
      write_reg(REG_PINS_PRESENT, CSR_DATA_W'(c.pins_present));
      csr_we <= 1'b0;
   endtask

   // response side: per-beat random stall, one long hold-off during the burst
   initial begin
      int n;
      int left;
      bit calm;
      rsp_stall = 1'b0;
      calm = 1'b0;
      left = $urandom_range(10, 60);
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = pick_gap(calm);
         if (hold_on && !hold_done) begin
            n = n + 48;
            hold_done = 1'b1;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
         if (--left == 0) begin
            calm = ~calm;
            left = $urandom_range(10, 60);
         end
      end
   end

   // stimulus
   initial begin
      cfg_type c;
      int      beats;
      int      n;
      int      p_high;
      int      p_start;
      int      phase_no;
      bit      calm;

      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_on   = 1'b0;
      reset     = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // two pulses with the lines held stuck, a start while busy is ignored
      c = '{half_period_ticks: 16'd1, max_pulses: 4'd2, settle_ticks: 16'd0,
            pins_present: 1'b1};
      program_cfg(c, 1'b0);
      send_item('{start_req: 1'b1, scl_level: 1'b0, sda_level: 1'b0}, pick_gap(1'b0));
      for (int i = 0; i < 11; i++)
         send_item('{start_req: (i == 4), scl_level: 1'b0, sda_level: 1'(i)},
                   pick_gap(1'b0));
      wait_drained();

      // no recovery pins: unsupported on the start beat
      c.pins_present = 1'b0;
      program_cfg(c, 1'b0);
      send_item('{start_req: 1'b1, scl_level: 1'b1, sda_level: 1'b1}, pick_gap(1'b0));
      send_item('{start_req: 1'b0, scl_level: 1'b1, sda_level: 1'b1}, pick_gap(1'b0));
      wait_drained();

      // zero-length phases, lines free: early stop and recovered
      c = '{half_period_ticks: 16'd0, max_pulses: 4'd15, settle_ticks: 16'd0,
            pins_present: 1'b1};
      program_cfg(c, 1'b0);
      send_item('{start_req: 1'b1, scl_level: 1'b1, sda_level: 1'b1}, pick_gap(1'b0));
      repeat (6)
         send_item('{start_req: 1'b0, scl_level: 1'b1, sda_level: 1'b1}, pick_gap(1'b0));
      wait_drained();

      // longest phases and no pulses, plus a write to an unused index
      c = '{half_period_ticks: 16'hffff, max_pulses: 4'd0, settle_ticks: 16'hffff,
            pins_present: 1'b1};
      program_cfg(c, 1'b1);
      send_item('{start_req: 1'b1, scl_level: 1'b1, sda_level: 1'b0}, pick_gap(1'b0));
      send_item('{start_req: 1'b0, scl_level: 1'b0, sda_level: 1'b1}, pick_gap(1'b0));
      send_item('{start_req: 1'b1, scl_level: 1'b0, sda_level: 1'b0}, pick_gap(1'b0));
      wait_drained();

      // random phases, each under a fresh register setting
      beats    = 0;
      phase_no = 0;
      while (beats < TARGET_BEATS) begin
         c.half_period_ticks = pick_len();
         c.settle_ticks      = pick_len();
         c.max_pulses        = 4'($urandom_range(0, 15));
         c.pins_present      = ($urandom_range(0, 99) < 85);
         program_cfg(c, $urandom_range(0, 99) < 20);
         case ($urandom_range(0, 3))
            0:       p_high = 0;
            1:       p_high = 25;
            2:       p_high = 60;
            default: p_high = 100;
         endcase
         p_start = $urandom_range(5, 40);
         if (phase_no == 2) begin
            // back-to-back beats against a long response hold-off
            hold_on = 1'b1;
            calm    = 1'b1;
            n       = 60;
         end else begin
            calm = ($urandom_range(0, 99) < 30);
            n    = $urandom_range(15, 70);
         end
         repeat (n)
            send_item(draw_item(p_high, p_start), pick_gap(calm));
         beats += n;
         phase_no++;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
